// File: hw/rtl/srs_pkg.sv
// shared types, codes and helpers of the selective-repeat sender
package srs_pkg;

  localparam int WINDOW_MAX_DEF = 32;
  localparam int SEQ_BITS_DEF   = 16;

  localparam int REQ_W      = 2;
  localparam int ACK_W      = 16;
  localparam int SEQ_OUT_W  = 16;
  localparam int PAYLOAD_W  = 7;
  localparam int WIN_SIZE_W = 6;
  localparam int TOTAL_W    = 16;
  localparam int TIMER_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int M26_W      = 5;

  localparam logic [REQ_W-1:0] REQ_ACK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PKT_TOTAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RST  = 6'd1;
  localparam logic [TOTAL_W-1:0]    PKT_TOTAL_RST = 16'd0;
  localparam logic [TIMER_W-1:0]    TIMEOUT_RST   = 8'd10;

  localparam logic [PAYLOAD_W-1:0] CHAR_A   = 7'd65;
  localparam logic [M26_W-1:0]     M26_LAST = 5'd25;

  typedef struct packed {
    logic [WIN_SIZE_W-1:0] win_size;
    logic [TOTAL_W-1:0]    pkt_total;
    logic [TIMER_W-1:0]    timeout;
  } cfg_t;

  typedef struct packed {
    logic                 carries_packet;
    logic [SEQ_OUT_W-1:0] seq_num;
    logic [PAYLOAD_W-1:0] payload;
    logic                 is_retransmission;
    logic                 last;
    logic                 done_res;
  } result_t;

  function automatic logic [M26_W-1:0] inc_m26(input logic [M26_W-1:0] m);
    return (m == M26_LAST) ? '0 : m + M26_W'(1);
  endfunction

  function automatic result_t make_packet(input logic [SEQ_OUT_W-1:0] seq,
                                          input logic [M26_W-1:0] m26,
                                          input logic retx, input logic last,
                                          input logic done);
    result_t r;
    r.carries_packet    = 1'b1;
    r.seq_num           = seq;
    r.payload           = CHAR_A + PAYLOAD_W'(m26);
    r.is_retransmission = retx;
    r.last              = last;
    r.done_res          = done;
    return r;
  endfunction

  function automatic result_t make_status(input logic done);
    result_t r;
    r          = '0;
    r.last     = 1'b1;
    r.done_res = done;
    return r;
  endfunction

endpackage

// File: hw/rtl/selective_repeat_sender.sv
// selective-repeat arq sender top level with output register
//
// Input items arrive on s_tvalid/s_tready: s_tuser is the request kind
// (ack arrival, send opportunity, timer tick), s_tdata the acked sequence.
// Every item gives one or more results on m_tvalid/m_tready, the final one
// marked by m_tlast; an item that sends nothing gives one status result.
// Configuration (window size, packet total, timeout) is written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write it only while
// no item is in progress, the block does not enforce it. A send gives at
// most 32 packets, else one status result; an ack outside the window is
// ignored, else the window base slides over the acked slots; a tick walks
// the outstanding slots. The timer ram has one read and one write port, so
// the tick walk covers one slot per cycle. Results leave through a one-deep
// output register; a new item is accepted as soon as the sequencer is idle,
// even while the final result still waits there. A stalled receiver holds
// the walk in place. Reset clears the window, sequence counters and ack flags
// and restores the configuration defaults; it needs no clearing pass.
module selective_repeat_sender #(
  parameter int WINDOW_MAX = srs_pkg::WINDOW_MAX_DEF,
  parameter int SEQ_BITS   = srs_pkg::SEQ_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [srs_pkg::ACK_W-1:0]      s_tdata,   // ack_num
  input  logic [srs_pkg::REQ_W-1:0]      s_tuser,   // req_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,   // seq_num, payload, done_res
  output logic [1:0]                     m_tuser,   // carries_packet, is_retransmission
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srs_pkg::*;

  cfg_t    cfg;
  result_t res, out_r;
  logic    idle, emit, out_free;

  srs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srs_ctrl #(.WINDOW_MAX(WINDOW_MAX), .SEQ_BITS(SEQ_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (s_tvalid && s_tready),
    .start_req (s_tuser),
    .start_ack (s_tdata),
    .idle      (idle),
    .out_free  (out_free),
    .emit      (emit),
    .res       (res)
  );

  assign s_tready = idle;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
    if (out_free && emit) begin
      out_r <= res;
    end
  end

  assign m_tdata = {out_r.done_res, out_r.payload, out_r.seq_num};
  assign m_tuser = {out_r.is_retransmission, out_r.carries_packet};
  assign m_tlast = out_r.last;

endmodule

// File: hw/rtl/srs_ram.sv
// generic single-port-write ram with registered read
module srs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/srs_cfg.sv
// configuration registers of the selective-repeat sender
module srs_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data,
  output srs_pkg::cfg_t                  cfg
);
  import srs_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_size  <= WIN_SIZE_RST;
      cfg.pkt_total <= PKT_TOTAL_RST;
      cfg.timeout   <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIN_SIZE:  cfg.win_size  <= cfg_data[WIN_SIZE_W-1:0];
        CFG_PKT_TOTAL: cfg.pkt_total <= cfg_data[TOTAL_W-1:0];
        CFG_TIMEOUT:   cfg.timeout   <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/srs_ctrl.sv
// window sequencer: send, ack slide and timer walk over the slot timer ram
module srs_ctrl #(
  parameter int WINDOW_MAX = srs_pkg::WINDOW_MAX_DEF,
  parameter int SEQ_BITS   = srs_pkg::SEQ_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  srs_pkg::cfg_t             cfg,
  input  logic                      start,
  input  logic [srs_pkg::REQ_W-1:0] start_req,
  input  logic [srs_pkg::ACK_W-1:0] start_ack,
  output logic                      idle,
  input  logic                      out_free,
  output logic                      emit,
  output srs_pkg::result_t          res
);
  import srs_pkg::*;

  localparam int SLW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW  = ((SEQ_BITS > SEQ_OUT_W) ? SEQ_BITS : SEQ_OUT_W) + 1;
  localparam int NW  = $clog2(WINDOW_MAX + 1);
  localparam int EWW = (NW > WIN_SIZE_W) ? NW : WIN_SIZE_W;
  localparam logic [CW-1:0]    SEQ_MAX   = {{(CW-SEQ_BITS){1'b0}}, {SEQ_BITS{1'b1}}};
  localparam logic [EWW-1:0]   WM_E      = EWW'(WINDOW_MAX);
  localparam logic [SLW:0]     WM_S      = (SLW+1)'(WINDOW_MAX);
  localparam logic [SLW-1:0]   SLOT_LAST = SLW'(WINDOW_MAX - 1);
  localparam logic [NW-1:0]    CNT_LAST  = NW'(WINDOW_MAX - 1);
  localparam logic [NW-1:0]    CNT_MAX   = NW'(WINDOW_MAX);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_SLIDE, ST_SEND, ST_TICK, ST_FIN
  } state_t;

  state_t                state;
  logic [REQ_W-1:0]      req_r;
  logic [ACK_W-1:0]      ack_r;
  logic [SEQ_BITS-1:0]   base, next_seq, limit, walk_seq, rd_seq, held_seq;
  logic [SLW-1:0]        base_slot, next_slot, walk_slot, rd_slot;
  logic [M26_W-1:0]      base_m26, next_m26, walk_m26, rd_m26, held_m26;
  logic [NW-1:0]         cnt;
  logic                  rd_valid, held_valid;
  logic [WINDOW_MAX-1:0] slot_acked;

  logic                  ram_we, ram_re;
  logic [SLW-1:0]        ram_waddr, ram_raddr;
  logic [TIMER_W-1:0]    ram_wdata, ram_rdata;

  logic [EWW-1:0]        eff_win;
  logic [CW-1:0]         eff_tot, tot_ext, base_ext, win_end, ack_ext, ack_diff;
  logic [SLW:0]          ack_sum;
  logic [SLW-1:0]        ack_slot;
  logic                  in_win, done, send_ok, send_last, walk_more;
  logic                  rd_acked, expire, stall;
  logic [TIMER_W:0]      t_inc;

  function automatic logic [SLW-1:0] inc_slot(input logic [SLW-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SLW'(1);
  endfunction

  function automatic logic [SEQ_OUT_W-1:0] seq_out(input logic [SEQ_BITS-1:0] s);
    logic [CW-1:0] w;
    w = CW'(s);
    return w[SEQ_OUT_W-1:0];
  endfunction

  srs_ram #(.WIDTH(TIMER_W), .DEPTH(WINDOW_MAX)) u_timer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign eff_win  = (EWW'(cfg.win_size) > WM_E) ? WM_E : EWW'(cfg.win_size);
  assign tot_ext  = CW'(cfg.pkt_total);
  assign eff_tot  = (tot_ext > SEQ_MAX) ? SEQ_MAX : tot_ext;
  assign base_ext = CW'(base);
  assign win_end  = base_ext + CW'(eff_win);
  assign ack_ext  = CW'(ack_r);
  assign in_win   = (ack_ext >= base_ext) && (ack_ext < win_end) && (ack_ext < eff_tot);
  assign ack_diff = ack_ext - base_ext;
  assign ack_sum  = {1'b0, base_slot} + {1'b0, ack_diff[SLW-1:0]};
  assign ack_slot = (ack_sum >= WM_S) ? SLW'(ack_sum - WM_S) : ack_sum[SLW-1:0];
  assign done     = base_ext >= eff_tot;

  assign send_ok   = (next_seq < limit) && (cnt < CNT_MAX);
  assign send_last = ((next_seq + SEQ_BITS'(1)) == limit) || (cnt == CNT_LAST);
  assign walk_more = walk_seq < limit;
  assign rd_acked  = slot_acked[rd_slot];
  assign t_inc     = {1'b0, ram_rdata} + (TIMER_W+1)'(1);
  assign expire    = t_inc >= {1'b0, cfg.timeout};
  assign stall     = rd_valid && !rd_acked && expire && held_valid && !out_free;
  assign idle      = (state == ST_IDLE);

  always_comb begin
    emit      = 1'b0;
    res       = make_status(done);
    ram_we    = 1'b0;
    ram_waddr = next_slot;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = walk_slot;
    unique case (state)
      ST_SEND: begin
        if (out_free) begin
          emit = 1'b1;
          if (send_ok) begin
            res    = make_packet(seq_out(next_seq), next_m26, 1'b0, send_last, done);
            ram_we = 1'b1;
          end
        end
      end
      ST_TICK: begin
        if (!stall) begin
          if (rd_valid && !rd_acked) begin
            ram_we    = 1'b1;
            ram_waddr = rd_slot;
            ram_wdata = expire ? '0 : t_inc[TIMER_W-1:0];
            if (expire && held_valid) begin
              emit = 1'b1;
              res  = make_packet(seq_out(held_seq), held_m26, 1'b1, 1'b0, done);
            end
          end
          ram_re = walk_more;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (held_valid) begin
            res = make_packet(seq_out(held_seq), held_m26, 1'b1, 1'b1, done);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      base       <= '0;
      base_slot  <= '0;
      base_m26   <= '0;
      next_seq   <= '0;
      next_slot  <= '0;
      next_m26   <= '0;
      slot_acked <= '0;
      rd_valid   <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req_r <= start_req;
            ack_r <= start_ack;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          unique case (req_r)
            REQ_ACK: begin
              if (in_win) begin
                slot_acked[ack_slot] <= 1'b1;
                state                <= ST_SLIDE;
              end else begin
                state <= ST_FIN;
              end
            end
            REQ_SEND: begin
              limit <= (win_end < eff_tot) ? SEQ_BITS'(win_end) : SEQ_BITS'(eff_tot);
              cnt   <= '0;
              state <= ST_SEND;
            end
            REQ_TICK: begin
              limit     <= (CW'(next_seq) < win_end) ? next_seq : SEQ_BITS'(win_end);
              walk_seq  <= base;
              walk_slot <= base_slot;
              walk_m26  <= base_m26;
              state     <= ST_TICK;
            end
            default: state <= ST_FIN;
          endcase
        end
        ST_SLIDE: begin
          if (!done && slot_acked[base_slot]) begin
            slot_acked[base_slot] <= 1'b0;
            base                  <= base + SEQ_BITS'(1);
            base_slot             <= inc_slot(base_slot);
            base_m26              <= inc_m26(base_m26);
          end else begin
            state <= ST_FIN;
          end
        end
        ST_SEND: begin
          if (out_free) begin
            if (send_ok) begin
              next_seq  <= next_seq + SEQ_BITS'(1);
              next_slot <= inc_slot(next_slot);
              next_m26  <= inc_m26(next_m26);
              cnt       <= cnt + NW'(1);
              if (send_last) begin
                state <= ST_IDLE;
              end
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_TICK: begin
          if (!stall) begin
            if (rd_valid && !rd_acked && expire) begin
              held_valid <= 1'b1;
              held_seq   <= rd_seq;
              held_m26   <= rd_m26;
            end
            if (walk_more) begin
              rd_valid  <= 1'b1;
              rd_seq    <= walk_seq;
              rd_slot   <= walk_slot;
              rd_m26    <= walk_m26;
              walk_seq  <= walk_seq + SEQ_BITS'(1);
              walk_slot <= inc_slot(walk_slot);
              walk_m26  <= inc_m26(walk_m26);
            end else begin
              rd_valid <= 1'b0;
              if (!rd_valid) begin
                state <= ST_FIN;
              end
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            held_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free) else $error("result emitted into a full output stage");

  a_rd_tick: assert property (@(posedge clk) disable iff (rst)
    (state != ST_TICK) |-> !rd_valid) else $error("timer read in flight outside tick walk");

  a_held: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (state == ST_TICK || state == ST_FIN))
    else $error("held retransmission outside tick walk");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && res.last) |=> (state == ST_IDLE)) else $error("item not finished after last");

  a_ram_hazard: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("timer read and write hit the same slot");

endmodule
